// ===== rtl/hpdf_pkg.sv =====
// Shared constants, types and codes of the hashed point duplicate filter.
package hpdf_pkg;

    // Seen-map geometry (power of two)
    localparam int unsigned TABLE_SLOTS = 1048576;
    localparam int          SLOT_W      = $clog2(TABLE_SLOTS);

    // Hash modulus
    localparam longint unsigned HASH_PRIME = 64'd1000003;
    localparam int              PRIME_W    = $clog2(HASH_PRIME);

    // Field widths
    localparam int MAG_W      = 30;
    localparam int PT_W       = 31;
    localparam int CFG_W      = 20;
    localparam int SLOT_OUT_W = 20;

    // Paired value and its fold into 16-bit chunks
    localparam int PAIR_W  = 2 * (MAG_W + 1);
    localparam int FOLD_CW = 16;
    localparam int FOLD_N  = 4;
    localparam int FOLD_W  = FOLD_N * FOLD_CW;
    localparam int FPROD_W = FOLD_CW + PRIME_W;

    // Chunk weights 2^(16*i) mod prime
    localparam longint unsigned FOLD_T [FOLD_N] = '{
        64'd1 % HASH_PRIME,
        (64'd1 << 16) % HASH_PRIME,
        (64'd1 << 32) % HASH_PRIME,
        (64'd1 << 48) % HASH_PRIME
    };

    // Reducer input stays below prime * 2^QUOT_W
    localparam int QUOT_W = 21;
    localparam int RED_W  = PRIME_W + QUOT_W;
    localparam int QHI_W  = QUOT_W + 1;
    localparam int R_W    = PRIME_W + 2;
    localparam longint unsigned BARRETT_M = (64'd1 << RED_W) / HASH_PRIME;

    // Slot hash pipeline depth and lookup stage position
    localparam int HASH_LAT  = 12;
    localparam int PIPE_LAST = HASH_LAT + 1;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_HASH_MULT = 1'b0,
        CFG_HASH_ADD  = 1'b1
    } cfg_index_t;

    // Seen-map lookup request
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
    } lookup_req_t;

endpackage

// ===== rtl/hpdf_mod_reduce.sv =====
// Three-stage constant-reciprocal reduction modulo the hash prime.
module hpdf_mod_reduce (
    input  logic                         clk,
    input  logic [hpdf_pkg::RED_W-1:0]   din,
    output logic [hpdf_pkg::PRIME_W-1:0] dout
);
    import hpdf_pkg::*;

    localparam logic [QHI_W-1:0]   RECIP   = QHI_W'(BARRETT_M);
    localparam logic [PRIME_W-1:0] PRIME_V = PRIME_W'(HASH_PRIME);
    localparam logic [R_W-1:0]     P1      = R_W'(HASH_PRIME);
    localparam logic [R_W-1:0]     P2      = R_W'(2 * HASH_PRIME);

    logic [QHI_W-1:0]          s_hi;
    logic [2*QHI_W-1:0]        qm_next;
    logic [2*QHI_W-1:0]        qm_reg;
    logic [R_W-1:0]            low1_reg;
    logic [QUOT_W-1:0]         q_est;
    logic [QUOT_W+PRIME_W-1:0] qp_full;
    logic [R_W-1:0]            qp_low_reg;
    logic [R_W-1:0]            low2_reg;
    logic [R_W-1:0]            rem_raw;
    logic [R_W-1:0]            rem_next;
    logic [PRIME_W-1:0]        dout_reg;

    // Estimate the quotient from the top bits
    assign s_hi    = din[RED_W-1 -: QHI_W];
    assign qm_next = s_hi * RECIP;
    assign q_est   = qm_reg[2*QHI_W-2 -: QUOT_W];
    assign qp_full = q_est * PRIME_V;

    // Remainder is below three primes: correct with one subtract
    always_comb
    begin
        rem_raw = low2_reg - qp_low_reg;
        if (rem_raw >= P2)
        begin
            rem_next = rem_raw - P2;
        end
        else if (rem_raw >= P1)
        begin
            rem_next = rem_raw - P1;
        end
        else
        begin
            rem_next = rem_raw;
        end
    end

    // Advance the three stages
    always_ff @(posedge clk)
    begin
        qm_reg     <= qm_next;
        low1_reg   <= din[R_W-1:0];
        qp_low_reg <= qp_full[R_W-1:0];
        low2_reg   <= low1_reg;
        dout_reg   <= PRIME_W'(rem_next);
    end

    assign dout = dout_reg;

endmodule

// ===== rtl/hpdf_slot_hash.sv =====
// Pairing, fold, prime reduction and universal hash giving the seen-map slot.
module hpdf_slot_hash (
    input  logic                        clk,
    input  logic [hpdf_pkg::MAG_W-1:0]  x_mag,
    input  logic [hpdf_pkg::MAG_W-1:0]  y_mag,
    input  logic [hpdf_pkg::CFG_W-1:0]  hash_mult,
    input  logic [hpdf_pkg::CFG_W-1:0]  hash_add,
    output logic [hpdf_pkg::SLOT_W-1:0] slot
);
    import hpdf_pkg::*;

    logic                     lt;
    logic [MAG_W:0]           base;
    logic [MAG_W:0]           off_next;
    logic [PAIR_W-1:0]        sq_reg;
    logic [MAG_W:0]           off_reg;
    logic                     lt_reg;
    logic [PAIR_W-1:0]        pair_next;
    logic [PAIR_W-1:0]        pair_reg;
    logic [FOLD_W-1:0]        pair_ext;
    logic [FPROD_W-1:0]       fprod_reg [FOLD_N];
    logic [RED_W-1:0]         fold_next;
    logic [RED_W-1:0]         fold_reg;
    logic [PRIME_W-1:0]       vmod;
    logic [CFG_W+PRIME_W-1:0] hprod_reg;
    logic [RED_W-1:0]         hsum_reg;
    logic [PRIME_W-1:0]       hmod;

    // Select square base and offset of the pairing
    always_comb
    begin
        lt = (x_mag < y_mag);
        if (lt)
        begin
            base     = {1'b0, y_mag};
            off_next = {1'b0, x_mag};
        end
        else
        begin
            base     = {1'b0, x_mag} + 1'b1;
            off_next = {1'b0, y_mag} + 1'b1;
        end
    end

    // Combine square and offset
    assign pair_next = lt_reg ? (sq_reg + PAIR_W'(off_reg)) : (sq_reg - PAIR_W'(off_reg));
    assign pair_ext  = FOLD_W'(pair_reg);

    // Sum the weighted chunks
    always_comb
    begin
        fold_next = '0;
        for (int i = 0; i < FOLD_N; i++)
        begin
            fold_next = fold_next + RED_W'(fprod_reg[i]);
        end
    end

    // Advance pairing, fold and hash stages
    always_ff @(posedge clk)
    begin
        sq_reg   <= base * base;
        off_reg  <= off_next;
        lt_reg   <= lt;
        pair_reg <= pair_next;
        for (int i = 0; i < FOLD_N; i++)
        begin
            fprod_reg[i] <= pair_ext[i*FOLD_CW +: FOLD_CW] * PRIME_W'(FOLD_T[i]);
        end
        fold_reg  <= fold_next;
        hprod_reg <= hash_mult * vmod;
        hsum_reg  <= RED_W'(hprod_reg) + RED_W'(hash_add);
    end

    // Reduce the paired value
    hpdf_mod_reduce u_reduce_pair (
        .clk  (clk),
        .din  (fold_reg),
        .dout (vmod)
    );

    // Reduce the hash
    hpdf_mod_reduce u_reduce_hash (
        .clk  (clk),
        .din  (hsum_reg),
        .dout (hmod)
    );

    assign slot = SLOT_W'(hmod);

endmodule

// ===== rtl/hpdf_seen_map.sv =====
// Seen-bitmap memory with read-modify-write, forwarding and clearing pass.
module hpdf_seen_map (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hpdf_pkg::lookup_req_t req,
    output logic                  hit,
    output logic                  clearing
);
    import hpdf_pkg::*;

    logic              mem [TABLE_SLOTS];
    logic              rd_reg;
    logic              clearing_reg;
    logic [SLOT_W-1:0] clr_idx_reg;
    logic              valid1_reg;
    logic              valid2_reg;
    logic [SLOT_W-1:0] slot1_reg;
    logic [SLOT_W-1:0] slot2_reg;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic              wr_bit;

    // Pick clearing write or mark of the looked-up slot
    always_comb
    begin
        if (clearing_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_idx_reg;
            wr_bit  = 1'b0;
        end
        else
        begin
            wr_en   = valid1_reg;
            wr_addr = slot1_reg;
            wr_bit  = 1'b1;
        end
    end

    // Memory port: write, and read with registered data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_bit;
        end
        rd_reg <= mem[req.slot];
    end

    // Sweep the map after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
            valid1_reg   <= 1'b0;
            valid2_reg   <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == SLOT_W'(TABLE_SLOTS - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            valid1_reg <= req.valid;
            valid2_reg <= valid1_reg;
        end
    end

    // Hold slots of the lookup and write-back stages
    always_ff @(posedge clk)
    begin
        slot1_reg <= req.slot;
        slot2_reg <= slot1_reg;
    end

    // Forward the mark written in the cycle of this read
    assign hit      = rd_reg | (valid2_reg && (slot2_reg == slot1_reg));
    assign clearing = clearing_reg;

endmodule

// ===== rtl/hashed_point_duplicate_filter_unit.sv =====
// Hashed point duplicate filter: top level with config, pipeline and results.
// Results: done strobes once the request has passed the slot hash, the seen-map lookup and the result registers.
// Throughput: one request per cycle while busy is low; the seen-map read-modify-write is forwarded.
// Reset: hash_mult = 1, hash_add = 0; then a clearing pass over all 1048576 map slots
// (one map slot per cycle) holds busy high. The receiver cannot stall results.
module hashed_point_duplicate_filter_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [hpdf_pkg::MAG_W-1:0]           x_magnitude,
    input  logic [hpdf_pkg::MAG_W-1:0]           y_magnitude,
    input  logic                                 x_negative,
    input  logic                                 y_negative,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  hpdf_pkg::cfg_index_t                 cfg_index,
    input  logic [hpdf_pkg::CFG_W-1:0]           cfg_data,
    output logic                                 done,
    output logic                                 accepted,
    output logic signed [hpdf_pkg::PT_W-1:0]     point_x,
    output logic signed [hpdf_pkg::PT_W-1:0]     point_y,
    output logic [hpdf_pkg::SLOT_OUT_W-1:0]      slot_index
);
    import hpdf_pkg::*;

    logic               accept;
    logic               clearing;
    logic               hit;
    logic [CFG_W-1:0]   hash_mult_reg;
    logic [CFG_W-1:0]   hash_add_reg;
    logic [MAG_W-1:0]   xm_reg;
    logic [MAG_W-1:0]   ym_reg;
    logic               vld_reg [PIPE_LAST+1];
    logic [PT_W-1:0]    px_reg  [PIPE_LAST+1];
    logic [PT_W-1:0]    py_reg  [PIPE_LAST+1];
    logic [PT_W-1:0]    px_next;
    logic [PT_W-1:0]    py_next;
    logic [SLOT_W-1:0]  slot;
    logic [SLOT_W-1:0]  slot_m1_reg;
    lookup_req_t        req;
    logic               done_reg;
    logic               accepted_reg;
    logic [PT_W-1:0]    point_x_reg;
    logic [PT_W-1:0]    point_y_reg;
    logic [SLOT_OUT_W-1:0] slot_index_reg;

    assign busy      = clearing;
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    // Apply the signs; a negated zero stays zero
    assign px_next = x_negative ? (PT_W'(0) - PT_W'(x_magnitude)) : PT_W'(x_magnitude);
    assign py_next = y_negative ? (PT_W'(0) - PT_W'(y_magnitude)) : PT_W'(y_magnitude);

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_mult_reg <= CFG_W'(1);
            hash_add_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_HASH_MULT: hash_mult_reg <= cfg_data;
                CFG_HASH_ADD:  hash_add_reg  <= cfg_data;
                default:       hash_add_reg  <= hash_add_reg;
            endcase
        end
    end

    // Advance request valid chain and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= PIPE_LAST; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= accept;
            for (int i = 1; i <= PIPE_LAST; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
            done_reg <= vld_reg[PIPE_LAST];
        end
    end

    // Carry the point alongside the hash and lookup
    always_ff @(posedge clk)
    begin
        xm_reg    <= x_magnitude;
        ym_reg    <= y_magnitude;
        px_reg[0] <= px_next;
        py_reg[0] <= py_next;
        for (int i = 1; i <= PIPE_LAST; i++)
        begin
            px_reg[i] <= px_reg[i-1];
            py_reg[i] <= py_reg[i-1];
        end
        slot_m1_reg    <= slot;
        accepted_reg   <= !hit;
        point_x_reg    <= px_reg[PIPE_LAST];
        point_y_reg    <= py_reg[PIPE_LAST];
        slot_index_reg <= SLOT_OUT_W'(slot_m1_reg);
    end

    // Compute the slot
    hpdf_slot_hash u_slot_hash (
        .clk       (clk),
        .x_mag     (xm_reg),
        .y_mag     (ym_reg),
        .hash_mult (hash_mult_reg),
        .hash_add  (hash_add_reg),
        .slot      (slot)
    );

    assign req.valid = vld_reg[HASH_LAT];
    assign req.slot  = slot;

    // Test and mark the slot
    hpdf_seen_map u_seen_map (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .hit      (hit),
        .clearing (clearing)
    );

    assign done       = done_reg;
    assign accepted   = accepted_reg;
    assign point_x    = point_x_reg;
    assign point_y    = point_y_reg;
    assign slot_index = slot_index_reg;

endmodule

// ===== dv/tb_hashed_point_duplicate_filter_unit.sv =====
// Testbench for the hashed point duplicate filter: random and directed points vs a predictor.
module tb_hashed_point_duplicate_filter_unit;
    import hpdf_pkg::*;

    localparam int unsigned RANDOM_PER_PHASE = 240;
    localparam longint unsigned RUN_LIMIT = 64'd50_000_000;

    typedef struct packed {
        logic [MAG_W-1:0] x_mag;
        logic [MAG_W-1:0] y_mag;
        logic             x_neg;
        logic             y_neg;
    } point_req_t;

    typedef struct packed {
        logic                  accepted;
        logic [PT_W-1:0]       point_x;
        logic [PT_W-1:0]       point_y;
        logic [SLOT_OUT_W-1:0] slot;
    } point_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [MAG_W-1:0]       x_magnitude = '0;
    logic [MAG_W-1:0]       y_magnitude = '0;
    logic                   x_negative = 1'b0;
    logic                   y_negative = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    cfg_index_t             cfg_index = CFG_HASH_MULT;
    logic [CFG_W-1:0]       cfg_data = '0;
    logic                   done;
    logic                   accepted;
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;
    logic [SLOT_OUT_W-1:0]  slot_index;

    // Predictor state: hash registers and the map of claimed slots
    longint unsigned mult_setting = 1;
    longint unsigned add_setting = 0;
    bit              seen_slots [longint unsigned];

    point_req_t      pending_points [$];
    point_req_t      sent_points [$];
    point_result_t   awaited_results [$];
    int unsigned     gap_left = 0;
    int unsigned     burst_left = 0;
    int unsigned     mismatch_count = 0;

    hashed_point_duplicate_filter_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .x_magnitude (x_magnitude),
        .y_magnitude (y_magnitude),
        .x_negative  (x_negative),
        .y_negative  (y_negative),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .accepted    (accepted),
        .point_x     (point_x),
        .point_y     (point_y),
        .slot_index  (slot_index)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Negate a magnitude into 31-bit two's complement; minus zero stays zero
    function automatic logic [PT_W-1:0] signed_coord(input logic [MAG_W-1:0] mag,
                                                     input logic neg);
        logic [PT_W-1:0] wide;
        wide = {1'b0, mag};
        return neg ? -wide : wide;
    endfunction

    // Pair the magnitudes, hash to a slot, and claim the slot if it is free
    function automatic point_result_t filter_point(input point_req_t p);
        longint unsigned r;
        longint unsigned c;
        longint unsigned paired;
        longint unsigned slot;
        point_result_t   res;
        r = p.x_mag;
        c = p.y_mag;
        if (r < c)
            paired = c * c + r;
        else
            paired = (r + 1) * (r + 1) - (c + 1);
        slot = ((mult_setting * (paired % HASH_PRIME) + add_setting) % HASH_PRIME)
               % TABLE_SLOTS;
        res.accepted = !seen_slots.exists(slot);
        seen_slots[slot] = 1'b1;
        res.point_x = signed_coord(p.x_mag, p.x_neg);
        res.point_y = signed_coord(p.y_mag, p.y_neg);
        res.slot = slot[SLOT_OUT_W-1:0];
        return res;
    endfunction

    // Idle length after a request: mostly none, some short, a few long, some bursts
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (burst_left != 0)
        begin
            burst_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 4)
        begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [MAG_W-1:0] edge_mag();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return MAG_W'(999999999);
            2: return '1;
            default: return MAG_W'(1) << $urandom_range(0, MAG_W - 1);
        endcase
    endfunction

    // Random point: repeats of earlier points, small values, edges, full range
    function automatic point_req_t random_point();
        point_req_t  p;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 35 && sent_points.size() != 0)
            p = sent_points[$urandom_range(0, sent_points.size() - 1)];
        else if (roll < 60)
        begin
            p.x_mag = MAG_W'($urandom_range(0, 31));
            p.y_mag = MAG_W'($urandom_range(0, 31));
        end
        else if (roll < 70)
        begin
            p.x_mag = edge_mag();
            p.y_mag = edge_mag();
        end
        else if (roll < 85)
        begin
            p.x_mag = MAG_W'($urandom_range(0, 999999999));
            p.y_mag = MAG_W'($urandom_range(0, 999999999));
        end
        else
        begin
            p.x_mag = MAG_W'($urandom);
            p.y_mag = MAG_W'($urandom);
        end
        p.x_neg = 1'($urandom_range(0, 1));
        p.y_neg = 1'($urandom_range(0, 1));
        return p;
    endfunction

    task automatic queue_point(input logic [MAG_W-1:0] xm, input logic [MAG_W-1:0] ym,
                               input logic xn, input logic yn);
        point_req_t p;
        p = '{x_mag: xm, y_mag: ym, x_neg: xn, y_neg: yn};
        pending_points.push_back(p);
        sent_points.push_back(p);
    endtask

    // Write one hash register and track it once the channel takes it
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_HASH_MULT)
            mult_setting = val;
        else
            add_setting = val;
    endtask

    // Hold until every request went in and every result came back
    task automatic wait_drained();
        while (pending_points.size() != 0 || start || awaited_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] mult, input logic [CFG_W-1:0] add,
                             input int unsigned count);
        point_req_t p;
        write_reg(CFG_HASH_MULT, mult);
        write_reg(CFG_HASH_ADD, add);
        repeat (count)
        begin
            p = random_point();
            queue_point(p.x_mag, p.y_mag, p.x_neg, p.y_neg);
        end
        wait_drained();
    endtask

    // Driver: present the front request, advance on acceptance, insert idle gaps
    always @(posedge clk)
    begin : request_driver
        point_req_t req;
        if (rst_n && !(start && busy))
        begin
            if (start)
            begin
                req = pending_points.pop_front();
                awaited_results.push_back(filter_point(req));
                gap_left = pick_gap();
            end
            if (gap_left != 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_points.size() != 0)
            begin
                start <= 1'b1;
                x_magnitude <= pending_points[0].x_mag;
                y_magnitude <= pending_points[0].y_mag;
                x_negative <= pending_points[0].x_neg;
                y_negative <= pending_points[0].y_neg;
            end
            else
                start <= 1'b0;
        end
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Monitor: check each strobed result against the oldest prediction
    always @(posedge clk)
    begin : result_monitor
        point_result_t want;
        if (rst_n && done)
        begin
            if (awaited_results.size() == 0)
                report_mismatch("result strobe with no request outstanding");
            else
            begin
                want = awaited_results.pop_front();
                if (accepted !== want.accepted)
                    report_mismatch($sformatf("accepted got %b want %b",
                                              accepted, want.accepted));
                if (point_x !== want.point_x)
                    report_mismatch($sformatf("point_x got %0d want %0d",
                                              point_x, $signed(want.point_x)));
                if (point_y !== want.point_y)
                    report_mismatch($sformatf("point_y got %0d want %0d",
                                              point_y, $signed(want.point_y)));
                if (slot_index !== want.slot)
                    report_mismatch($sformatf("slot_index got %0d want %0d",
                                              slot_index, want.slot));
            end
        end
    end

    initial
    begin : stimulus
        int unsigned ph;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed points under reset hash settings
        queue_point(0, 0, 0, 0);
        queue_point(0, 0, 1, 1);                      // minus zero, same slot
        queue_point(1, 2, 0, 1);                      // pairing with r below c
        queue_point(2, 1, 1, 0);                      // pairing with r at or above c
        queue_point(2, 1, 0, 0);                      // same magnitudes, x sign flipped
        queue_point(5, 5, 1, 1);
        queue_point(3, 1000, 0, 0);                   // pairs to the prime: collides with origin
        queue_point(1, 0, 1, 0);
        queue_point(0, 1, 0, 1);
        queue_point(999999999, 999999999, 0, 1);
        queue_point(999999999, 0, 1, 0);
        queue_point(0, 999999999, 0, 1);
        queue_point('1, '1, 1, 1);                    // magnitudes above range
        queue_point('1, 0, 0, 0);
        queue_point(0, '1, 1, 1);
        queue_point(30'h2AAAAAAA, 30'h15555555, 1, 0);
        queue_point(30'h15555555, 30'h2AAAAAAA, 0, 1);
        queue_point(30'h20000000, 1, 1, 1);
        queue_point(1000003, 0, 0, 0);
        queue_point(0, 0, 0, 1);
        repeat (RANDOM_PER_PHASE)
            sent_points.push_back(random_point());
        while (sent_points.size() > 20)
            pending_points.push_back(sent_points.pop_back());
        wait_drained();

        // Register corners, then random settings
        run_phase(0, 777, 100);                       // zero multiplier: one slot for all
        run_phase(1000002, 1000002, 300);
        run_phase('1, '1, 250);                       // registers above the prime
        run_phase(1000003, 0, 50);                    // multiplier equal to the prime
        for (ph = 0; ph < 3; ph++)
            run_phase(CFG_W'($urandom_range(1, 1000002)),
                      CFG_W'($urandom_range(0, 1000002)), 330);

        repeat (HASH_LAT + 10)
            @(posedge clk);
        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin : watchdog
        #(RUN_LIMIT);
        $display("TIMEOUT with %0d results outstanding", awaited_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
